[rtl/hsvr_pkg.sv]
// Shared types and constants of the HSV to RGB pixel converter.
package hsvr_pkg;

  // Field widths of the pixel channels.
  localparam int unsigned HUE_W = 16;
  localparam int unsigned PCT_W = 11;
  localparam int unsigned CH_W  = 8;

  // Default number of fraction bits of the fixed-point datapath.
  localparam int unsigned FRAC_BITS_DEF = 16;

  // Hue: 360 degrees in 1/64 degree, one sector is 60 degrees.
  localparam int unsigned FULL_TURN    = 23040;
  localparam int unsigned SECTOR_UNITS = 3840;

  // Percent scale: 100 percent in 1/16 percent.
  localparam int unsigned PERCENT_FULL = 1600;

  // 1600 = 25 << 6, so round(x * 2^F / 1600) = floor((x * 2^(F-6) + 12) / 25).
  localparam int unsigned PCT_SHIFT = 6;
  localparam int unsigned PCT_DIV   = 25;
  localparam int unsigned PCT_BIAS  = (PCT_DIV - 1) / 2;

  // 3840 = 15 << 8, so round(r * 2^F / 3840) = floor((r * 2^(F-8) + 7) / 15).
  localparam int unsigned SEC_SHIFT = 8;
  localparam int unsigned SEC_DIV   = 15;
  localparam int unsigned SEC_BIAS  = (SEC_DIV - 1) / 2;

  // Hue sectors of 60 degrees each.
  typedef enum logic [2:0] {
    SEC_RED     = 3'd0,
    SEC_YELLOW  = 3'd1,
    SEC_GREEN   = 3'd2,
    SEC_CYAN    = 3'd3,
    SEC_BLUE    = 3'd4,
    SEC_MAGENTA = 3'd5
  } sector_e;

endpackage

[rtl/hsvr_if.sv]
// Pixel channel interfaces: HSV input item and RGB result item.
interface hsvr_hsv_if;
  logic                          valid;
  logic                          ready;
  logic [hsvr_pkg::HUE_W-1:0]    hue;
  logic [hsvr_pkg::PCT_W-1:0]    saturation;
  logic [hsvr_pkg::PCT_W-1:0]    brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  output ready);
endinterface

interface hsvr_rgb_if;
  logic                       valid;
  logic                       ready;
  logic [hsvr_pkg::CH_W-1:0]  red;
  logic [hsvr_pkg::CH_W-1:0]  green;
  logic [hsvr_pkg::CH_W-1:0]  blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

[rtl/hsvr_cdiv.sv]
// Registered divider by a constant, using an exact reciprocal multiplication.
module hsvr_cdiv #(
  parameter int unsigned NUM_W   = 21,
  parameter int unsigned DIVISOR = 25,
  parameter int unsigned QUO_W   = 17
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  output logic [QUO_W-1:0] quo_o
);

  // With K = NUM_W + clog2(D) and M = ceil(2^K / D), (N * M) >> K is exactly
  // floor(N / D) for every N below 2^NUM_W.
  localparam int unsigned SH     = $clog2(DIVISOR);
  localparam int unsigned K      = NUM_W + SH;
  localparam int unsigned MULT_W = NUM_W + 2;
  localparam int unsigned PROD_W = NUM_W + MULT_W;
  localparam logic [63:0] MULT   = ((64'd1 << K) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);

  logic [PROD_W-1:0] prod;
  logic [QUO_W-1:0]  quo_q;

  // Reciprocal product.
  assign prod = {{MULT_W{1'b0}}, num_i} * {{NUM_W{1'b0}}, MULT[MULT_W-1:0]};

  // Quotient register.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quo_q <= prod[K +: QUO_W];
    end
  end

  assign quo_o = quo_q;

endmodule

[rtl/hsv_to_rgb_pixel_converter.sv]
// Top level of the HSV to RGB pixel converter: five-stage pipeline.
//
//  Port    Dir  Fields                          Handshake
//  hsv_i   in   hue, saturation, brightness     valid/ready, taken when both high
//  rgb_o   out  red, green, blue                valid/ready, taken when both high
//
// An item accepted at one clock edge is valid on rgb_o after five register stages;
// one item enters per cycle while hsv_i.ready is high. The depth follows the chain of
// dependent multiplies: the reciprocal dividers, then s*f and v*(1-s), then
// v*(1-s*f), then the byte scaling and the sector routing.
// Reset clears only the stage valid bits. A stall at rgb_o holds a full stage only if
// all later stages are full; empty stages keep filling, so hsv_i.ready drops only when all are full.
module hsv_to_rgb_pixel_converter #(
  parameter int unsigned FRAC_BITS = hsvr_pkg::FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  hsvr_hsv_if.sink           hsv_i,
  hsvr_rgb_if.source         rgb_o
);

  localparam int unsigned FB    = FRAC_BITS;
  localparam int unsigned QW    = FB + 1;
  localparam int unsigned NS_W  = hsvr_pkg::PCT_W + FB - hsvr_pkg::PCT_SHIFT;
  localparam int unsigned REM_W = $clog2(hsvr_pkg::SECTOR_UNITS);
  localparam int unsigned NF_W  = REM_W + FB - hsvr_pkg::SEC_SHIFT;
  localparam int unsigned H_W   = $clog2(hsvr_pkg::FULL_TURN);
  localparam int unsigned CW    = hsvr_pkg::CH_W;
  localparam logic [QW-1:0] ONE  = QW'(1) << FB;
  localparam logic [QW-1:0] HALF = QW'(1) << (FB - 1);

  // Fixed-point multiply with rounding: (a*b + half) >> FB.
  function automatic logic [QW-1:0] fx_mul(input logic [QW-1:0] a, input logic [QW-1:0] b);
    logic [2*QW-1:0] prod;
    prod = {{QW{1'b0}}, a} * {{QW{1'b0}}, b} + (2*QW)'(HALF);
    return prod[FB +: QW];
  endfunction

  // Scale a value in 0..ONE to a rounded byte: (x*255 + half) >> FB.
  function automatic logic [CW-1:0] to_byte(input logic [QW-1:0] x);
    logic [QW+CW-1:0] prod;
    prod = {x, {CW{1'b0}}} - {{CW{1'b0}}, x} + (QW+CW)'(HALF);
    return prod[FB +: CW];
  endfunction

  // Stage enables and valid bits.
  logic [5:1] en;
  logic [5:1] vld_q;

  always_comb begin
    en[5] = !vld_q[5] || rgb_o.ready;
    for (int k = 4; k >= 1; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign hsv_i.ready = en[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[1]) vld_q[1] <= hsv_i.valid;
      for (int k = 2; k <= 5; k++) begin
        if (en[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // Stage 1: clamp, hue wrap, sector split and divider numerators.
  logic [hsvr_pkg::PCT_W-1:0] sc, vc;
  logic [H_W-1:0]             h;
  hsvr_pkg::sector_e          sec;
  logic [REM_W-1:0]           rem;
  logic [H_W-1:0]             sec_base;

  always_comb begin
    sc = (hsv_i.saturation > hsvr_pkg::PCT_W'(hsvr_pkg::PERCENT_FULL)) ?
         hsvr_pkg::PCT_W'(hsvr_pkg::PERCENT_FULL) : hsv_i.saturation;
    vc = (hsv_i.brightness > hsvr_pkg::PCT_W'(hsvr_pkg::PERCENT_FULL)) ?
         hsvr_pkg::PCT_W'(hsvr_pkg::PERCENT_FULL) : hsv_i.brightness;
    // The hue field spans less than three turns.
    if (hsv_i.hue >= hsvr_pkg::HUE_W'(2 * hsvr_pkg::FULL_TURN)) begin
      h = H_W'(hsv_i.hue - hsvr_pkg::HUE_W'(2 * hsvr_pkg::FULL_TURN));
    end else if (hsv_i.hue >= hsvr_pkg::HUE_W'(hsvr_pkg::FULL_TURN)) begin
      h = H_W'(hsv_i.hue - hsvr_pkg::HUE_W'(hsvr_pkg::FULL_TURN));
    end else begin
      h = H_W'(hsv_i.hue);
    end
    if (h >= H_W'(5 * hsvr_pkg::SECTOR_UNITS)) begin
      sec = hsvr_pkg::SEC_MAGENTA;
    end else if (h >= H_W'(4 * hsvr_pkg::SECTOR_UNITS)) begin
      sec = hsvr_pkg::SEC_BLUE;
    end else if (h >= H_W'(3 * hsvr_pkg::SECTOR_UNITS)) begin
      sec = hsvr_pkg::SEC_CYAN;
    end else if (h >= H_W'(2 * hsvr_pkg::SECTOR_UNITS)) begin
      sec = hsvr_pkg::SEC_GREEN;
    end else if (h >= H_W'(hsvr_pkg::SECTOR_UNITS)) begin
      sec = hsvr_pkg::SEC_YELLOW;
    end else begin
      sec = hsvr_pkg::SEC_RED;
    end
    sec_base = H_W'(H_W'(sec) * H_W'(hsvr_pkg::SECTOR_UNITS));
    rem      = REM_W'(h - sec_base);
  end

  logic [NS_W-1:0]   ns_q, nv_q;
  logic [NF_W-1:0]   nf_q;
  hsvr_pkg::sector_e sec1_q;
  logic              gray1_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      ns_q    <= (NS_W'(sc) << (FB - hsvr_pkg::PCT_SHIFT)) + NS_W'(hsvr_pkg::PCT_BIAS);
      nv_q    <= (NS_W'(vc) << (FB - hsvr_pkg::PCT_SHIFT)) + NS_W'(hsvr_pkg::PCT_BIAS);
      nf_q    <= (NF_W'(rem) << (FB - hsvr_pkg::SEC_SHIFT)) + NF_W'(hsvr_pkg::SEC_BIAS);
      sec1_q  <= sec;
      gray1_q <= (hsv_i.saturation == '0);
    end
  end

  // Stage 2: s, v and f through the constant dividers.
  logic [QW-1:0]     s2, v2, f2;
  hsvr_pkg::sector_e sec2_q;
  logic              gray2_q;

  hsvr_cdiv #(.NUM_W(NS_W), .DIVISOR(hsvr_pkg::PCT_DIV), .QUO_W(QW)) u_div_s (
    .clk_i(clk_i), .en_i(en[2]), .num_i(ns_q), .quo_o(s2)
  );
  hsvr_cdiv #(.NUM_W(NS_W), .DIVISOR(hsvr_pkg::PCT_DIV), .QUO_W(QW)) u_div_v (
    .clk_i(clk_i), .en_i(en[2]), .num_i(nv_q), .quo_o(v2)
  );
  hsvr_cdiv #(.NUM_W(NF_W), .DIVISOR(hsvr_pkg::SEC_DIV), .QUO_W(QW)) u_div_f (
    .clk_i(clk_i), .en_i(en[2]), .num_i(nf_q), .quo_o(f2)
  );

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      sec2_q  <= sec1_q;
      gray2_q <= gray1_q;
    end
  end

  // Stage 3: p, s*f, s*(1-f), the value byte and the grey byte.
  logic [QW-1:0]     v3_q, p3_q, sf3_q, sfc3_q;
  logic [CW-1:0]     vu3_q, grey3_q;
  logic [QW+CW-1:0]  v255;
  hsvr_pkg::sector_e sec3_q;
  logic              gray3_q;

  assign v255 = {v2, {CW{1'b0}}} - {{CW{1'b0}}, v2};

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      v3_q    <= v2;
      p3_q    <= fx_mul(v2, ONE - s2);
      sf3_q   <= fx_mul(s2, f2);
      sfc3_q  <= fx_mul(s2, ONE - f2);
      vu3_q   <= to_byte(v2);
      grey3_q <= v255[FB +: CW];
      sec3_q  <= sec2_q;
      gray3_q <= gray2_q;
    end
  end

  // Stage 4: q, t and the p byte.
  logic [QW-1:0]     q4_q, t4_q;
  logic [CW-1:0]     vu4_q, pu4_q, grey4_q;
  hsvr_pkg::sector_e sec4_q;
  logic              gray4_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      q4_q    <= fx_mul(v3_q, ONE - sf3_q);
      t4_q    <= fx_mul(v3_q, ONE - sfc3_q);
      pu4_q   <= to_byte(p3_q);
      vu4_q   <= vu3_q;
      grey4_q <= grey3_q;
      sec4_q  <= sec3_q;
      gray4_q <= gray3_q;
    end
  end

  // Stage 5: q and t bytes, sector routing, output register.
  logic [CW-1:0] qu, tu, r_d, g_d, b_d;
  logic [CW-1:0] red_q, green_q, blue_q;

  always_comb begin
    qu = to_byte(q4_q);
    tu = to_byte(t4_q);
    case (sec4_q)
      hsvr_pkg::SEC_RED:    begin r_d = vu4_q; g_d = tu;    b_d = pu4_q; end
      hsvr_pkg::SEC_YELLOW: begin r_d = qu;    g_d = vu4_q; b_d = pu4_q; end
      hsvr_pkg::SEC_GREEN:  begin r_d = pu4_q; g_d = vu4_q; b_d = tu;    end
      hsvr_pkg::SEC_CYAN:   begin r_d = pu4_q; g_d = qu;    b_d = vu4_q; end
      hsvr_pkg::SEC_BLUE:   begin r_d = tu;    g_d = pu4_q; b_d = vu4_q; end
      default:              begin r_d = vu4_q; g_d = pu4_q; b_d = qu;    end
    endcase
    // Zero saturation gives a truncated grey on all channels.
    if (gray4_q) begin
      r_d = grey4_q;
      g_d = grey4_q;
      b_d = grey4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      red_q   <= r_d;
      green_q <= g_d;
      blue_q  <= b_d;
    end
  end

  assign rgb_o.valid = vld_q[5];
  assign rgb_o.red   = red_q;
  assign rgb_o.green = green_q;
  assign rgb_o.blue  = blue_q;

  // An accepted item occupies the first stage in the next cycle.
  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hsv_i.valid && hsv_i.ready |=> vld_q[1])
    else $error("accepted item missing from stage 1");

  // The input stalls only when every stage holds an item.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !hsv_i.ready |-> (vld_q == '1))
    else $error("input stalled with an empty stage");

  // Hue wrapping and sector split never yield an unused sector code.
  a_sector_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[1] |-> (sec1_q <= hsvr_pkg::SEC_MAGENTA))
    else $error("sector code out of range");

  // A grey item leaves with three equal channels.
  a_grey_equal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[4] && gray4_q && en[5] |=> (red_q == green_q) && (green_q == blue_q))
    else $error("grey item with unequal channels");

endmodule
